// ----- rtl/adpcm_nibble_encoder_macros.svh -----
// assertion macros for the adpcm nibble encoder
// expects clk and rst_n in the scope of each use
`ifndef ADPCM_NIBBLE_ENCODER_MACROS_SVH
`define ADPCM_NIBBLE_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define ADNE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adne check failed");
`define ADNE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adne check failed");
`else
`define ADNE_ASSERT_IMP(lbl, ante, cons)
`define ADNE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/adne_pkg.sv -----
// shared types, constants and the step scale table of the adpcm nibble encoder
// no dependencies
`default_nettype none

package adne_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 11;
  localparam int CODE_W   = 4;
  localparam int OUT_W    = 8;
  localparam int DIFF_W   = 17;
  localparam int ALU_W    = 20;
  localparam int MUL_A_W  = 11;
  localparam int MUL_B_W  = 8;
  localparam int MUL_P_W  = 19;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0]  DIV_LAST_CNT = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RESET   = 11'd10;
  localparam logic [STEP_W-1:0] STEP_MIN     = 11'd1;
  localparam logic [STEP_W-1:0] STEP_MAX     = 11'd2000;
  localparam logic signed [ALU_W-1:0] LEVEL_MAX = 20'sd32767;
  localparam logic signed [ALU_W-1:0] LEVEL_MIN = -20'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_CODE,
    ST_MULD,
    ST_LEVEL,
    ST_STEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  function automatic logic [MUL_B_W-1:0] step_scale(input logic [CODE_W-1:0] idx);
    logic [MUL_B_W-1:0] s;
    case (idx)
      4'd0, 4'd1, 4'd15:  s = 8'd154;
      4'd2, 4'd14:        s = 8'd128;
      4'd3, 4'd13:        s = 8'd102;
      4'd4, 4'd12:        s = 8'd77;
      default:            s = 8'd58;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/adne_if.sv -----
// valid/ready channels of the adpcm nibble encoder: sample in, packed codes out
// depends on adne_pkg
`default_nettype none

interface adne_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [adne_pkg::SAMPLE_W-1:0]   sample;
  logic                                   new_stream;

  modport source (output valid, output sample, output new_stream, input ready);
  modport sink   (input valid, input sample, input new_stream, output ready);
endinterface

interface adne_out_if;
  logic                          valid;
  logic                          ready;
  logic [adne_pkg::OUT_W-1:0]    packed_codes;

  modport source (output valid, output packed_codes, input ready);
  modport sink   (input valid, input packed_codes, output ready);
endinterface

`default_nettype wire

// ----- rtl/adpcm_nibble_encoder.sv -----
// adpcm_nibble_encoder: 4-bit adaptive-step adpcm encoder, two codes per byte
// depends on adne_pkg, adne_if, adne_alu, adne_mul and the macros header
//
// in_item carries a signed 16-bit sample and a new_stream flag; new_stream
// restarts the stream (level 0, step 10, pair phase cleared) before the sample
// is coded, dropping any unpaired code. out_item carries one byte for every
// second sample, the earlier code in the upper nibble.
// one item at a time: ready is high only while the sequencer idles. from
// acceptance to the output register an item goes through one difference,
// one magnitude, 17 restoring-division steps through the shared add/sub unit,
// then code, delta multiply, level update, step update and emit. most of an
// item's time goes to the division steps. a byte is valid the cycle after
// the emit cycle; a stalled receiver holds the byte in the output register,
// and a new item is still accepted meanwhile. only when the next byte is
// ready while the old one still waits does the sequencer hold in emit.
// reset (synchronous, active low) clears the level, sets the step to 10,
// clears the pair phase and empties the output register.
`default_nettype none
`include "adpcm_nibble_encoder_macros.svh"

module adpcm_nibble_encoder (
  input  wire        clk,
  input  wire        rst_n,
  adne_in_if.sink    in_item,
  adne_out_if.source out_item
);

  // sequencer and datapath state
  adne_pkg::state_t state_r, state_nxt;
  logic signed [adne_pkg::SAMPLE_W-1:0] level_r, level_nxt;
  logic [adne_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic                                 odd_r, odd_nxt;
  logic [adne_pkg::CODE_W-1:0]          held_r, held_nxt;
  logic [adne_pkg::DIFF_W-1:0]          quo_r, quo_nxt;   // difference, then quotient
  logic [adne_pkg::STEP_W-1:0]          rem_r, rem_nxt;
  logic                                 neg_r, neg_nxt;
  logic [adne_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [adne_pkg::CODE_W-1:0]          code_r, code_nxt;
  logic [adne_pkg::MUL_P_W-1:0]         prod_r, prod_nxt;
  logic                                 emit_r, emit_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [adne_pkg::OUT_W-1:0]           out_data_r, out_data_nxt;

  // shared units
  adne_pkg::alu_req_t                   alu_req;
  logic signed [adne_pkg::ALU_W-1:0]    alu_res;
  logic [adne_pkg::MUL_A_W-1:0]         mul_a;
  logic [adne_pkg::MUL_B_W-1:0]         mul_b;
  logic [adne_pkg::MUL_P_W-1:0]         mul_p;

  // helpers
  logic                                 in_acc;
  logic                                 out_free;
  logic                                 out_load;
  logic                                 code_le0;
  logic [adne_pkg::CODE_W-1:0]          mag;
  logic [4:0]                           qsat;
  logic [3:0]                           half_pos;
  logic [5:0]                           half_neg;
  logic [12:0]                          step_raw;

  adne_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  adne_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  assign in_item.ready         = (state_r == adne_pkg::ST_IDLE);
  assign in_acc                = in_item.valid && in_item.ready;
  assign out_item.valid        = out_valid_r;
  assign out_item.packed_codes = out_data_r;
  assign out_free              = !out_valid_r || out_item.ready;
  assign out_load              = (state_r == adne_pkg::ST_EMIT) && emit_r && out_free;

  // a code of zero or below rebuilds a negative delta
  assign code_le0 = code_r[adne_pkg::CODE_W-1] || (code_r == '0);
  assign mag      = code_r[adne_pkg::CODE_W-1] ? 4'(4'd0 - code_r) : code_r;

  // quotient saturated to 31 is enough for the final -8..7 clamp
  assign qsat     = (|quo_r[adne_pkg::DIFF_W-1:5]) ? 5'd31 : quo_r[4:0];
  assign half_pos = qsat[4:1];
  assign half_neg = 6'((6'({1'b0, qsat}) + 6'd1) >> 1);

  assign step_raw = prod_r[adne_pkg::MUL_P_W-1:6];

  // operand selection for the shared units
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    mul_a       = step_r;
    mul_b       = '0;
    case (state_r)
      adne_pkg::ST_IDLE: begin
        // sample minus predicted level, level taken as zero on a restart
        alu_req.a   = {{(adne_pkg::ALU_W-adne_pkg::SAMPLE_W){in_item.sample[15]}},
                       in_item.sample};
        alu_req.b   = in_item.new_stream ? '0 :
                      {{(adne_pkg::ALU_W-adne_pkg::SAMPLE_W){level_r[15]}}, level_r};
        alu_req.sub = 1'b1;
      end
      adne_pkg::ST_ABS: begin
        alu_req.a   = '0;
        alu_req.b   = {{(adne_pkg::ALU_W-adne_pkg::DIFF_W){quo_r[16]}}, quo_r};
        alu_req.sub = 1'b1;
      end
      adne_pkg::ST_DIV: begin
        // trial subtract of the step from the shifted partial remainder
        alu_req.a   = {{(adne_pkg::ALU_W-adne_pkg::STEP_W-1){1'b0}}, rem_r, quo_r[16]};
        alu_req.b   = {{(adne_pkg::ALU_W-adne_pkg::STEP_W){1'b0}}, step_r};
        alu_req.sub = 1'b1;
      end
      adne_pkg::ST_MULD: begin
        mul_b = {3'b000, mag, 1'b1};
      end
      adne_pkg::ST_LEVEL: begin
        alu_req.a   = {{(adne_pkg::ALU_W-adne_pkg::SAMPLE_W){level_r[15]}}, level_r};
        alu_req.b   = {{(adne_pkg::ALU_W-adne_pkg::MUL_P_W+1){1'b0}},
                       prod_r[adne_pkg::MUL_P_W-1:1]};
        alu_req.sub = code_le0;
        mul_b       = adne_pkg::step_scale({~code_r[3], code_r[2:0]});
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    step_nxt      = step_r;
    odd_nxt       = odd_r;
    held_nxt      = held_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    code_nxt      = code_r;
    prod_nxt      = prod_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      adne_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item.new_stream) begin
            level_nxt = '0;
            step_nxt  = adne_pkg::STEP_RESET;
            odd_nxt   = 1'b0;
          end
          quo_nxt   = alu_res[adne_pkg::DIFF_W-1:0];
          neg_nxt   = alu_res[adne_pkg::ALU_W-1];
          state_nxt = adne_pkg::ST_ABS;
        end
      end
      adne_pkg::ST_ABS: begin
        if (neg_r) begin
          quo_nxt = alu_res[adne_pkg::DIFF_W-1:0];
        end
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = adne_pkg::ST_DIV;
      end
      adne_pkg::ST_DIV: begin
        if (!alu_res[adne_pkg::ALU_W-1]) begin
          rem_nxt = alu_res[adne_pkg::STEP_W-1:0];
          quo_nxt = {quo_r[adne_pkg::DIFF_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[adne_pkg::STEP_W-2:0], quo_r[16]};
          quo_nxt = {quo_r[adne_pkg::DIFF_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == adne_pkg::DIV_LAST_CNT) begin
          state_nxt = adne_pkg::ST_CODE;
        end
      end
      adne_pkg::ST_CODE: begin
        // halve with floor, clamp to -8..7
        if (neg_r) begin
          code_nxt = (half_neg > 6'd8) ? 4'b1000 : 4'(6'd0 - half_neg);
        end else begin
          code_nxt = (half_pos > 4'd7) ? 4'd7 : half_pos;
        end
        if (odd_r) begin
          emit_nxt = 1'b1;
          odd_nxt  = 1'b0;
        end else begin
          emit_nxt = 1'b0;
          odd_nxt  = 1'b1;
        end
        state_nxt = adne_pkg::ST_MULD;
      end
      adne_pkg::ST_MULD: begin
        if (!emit_r) begin
          held_nxt = code_r;
        end
        prod_nxt  = mul_p;
        state_nxt = adne_pkg::ST_LEVEL;
      end
      adne_pkg::ST_LEVEL: begin
        if (alu_res > adne_pkg::LEVEL_MAX) begin
          level_nxt = adne_pkg::LEVEL_MAX[adne_pkg::SAMPLE_W-1:0];
        end else if (alu_res < adne_pkg::LEVEL_MIN) begin
          level_nxt = adne_pkg::LEVEL_MIN[adne_pkg::SAMPLE_W-1:0];
        end else begin
          level_nxt = alu_res[adne_pkg::SAMPLE_W-1:0];
        end
        prod_nxt  = mul_p;
        state_nxt = adne_pkg::ST_STEP;
      end
      adne_pkg::ST_STEP: begin
        // divide by 64, clamp to 1..2000
        if (step_raw > 13'(adne_pkg::STEP_MAX)) begin
          step_nxt = adne_pkg::STEP_MAX;
        end else if (step_raw == '0) begin
          step_nxt = adne_pkg::STEP_MIN;
        end else begin
          step_nxt = step_raw[adne_pkg::STEP_W-1:0];
        end
        state_nxt = adne_pkg::ST_EMIT;
      end
      adne_pkg::ST_EMIT: begin
        if (!emit_r) begin
          state_nxt = adne_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {held_r, code_r};
          state_nxt     = adne_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = adne_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adne_pkg::ST_IDLE;
      level_r     <= '0;
      step_r      <= adne_pkg::STEP_RESET;
      odd_r       <= 1'b0;
      held_r      <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      step_r      <= step_nxt;
      odd_r       <= odd_nxt;
      held_r      <= held_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    code_r     <= code_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // step stays within its clamp range
  `ADNE_ASSERT_IMP(a_step_range, 1'b1, (step_r != '0) && (step_r <= adne_pkg::STEP_MAX))
  // the partial remainder stays below the divisor during division
  `ADNE_ASSERT_IMP(a_rem_below_step, state_r == adne_pkg::ST_DIV, rem_r < step_r)
  // a byte is loaded only when a pair has just been completed
  `ADNE_ASSERT_IMP(a_load_clears_phase, out_load, !odd_r)
  // an accepted item starts the magnitude step next
  `ADNE_ASSERT_NXT(a_accept_starts, in_acc, state_r == adne_pkg::ST_ABS)

endmodule

`default_nettype wire

// ----- rtl/adne_alu.sv -----
// shared add/subtract unit: difference, magnitude, divider trial and level update
// depends on adne_pkg
`default_nettype none

module adne_alu (
  input  adne_pkg::alu_req_t                     req,
  output logic signed [adne_pkg::ALU_W-1:0]      res
);

  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

`default_nettype wire

// ----- rtl/adne_mul.sv -----
// shared small unsigned multiplier for the delta rebuild and the step adaptation
// depends on adne_pkg
`default_nettype none

module adne_mul (
  input  logic [adne_pkg::MUL_A_W-1:0] a,
  input  logic [adne_pkg::MUL_B_W-1:0] b,
  output logic [adne_pkg::MUL_P_W-1:0] p
);

  assign p = adne_pkg::MUL_P_W'(a) * adne_pkg::MUL_P_W'(b);

endmodule

`default_nettype wire

// ----- tb/tb_adpcm_nibble_encoder.sv -----
`timescale 1ns / 1ps
// testbench for adpcm_nibble_encoder: drives samples over adne_in_if and checks the
// packed code bytes on adne_out_if against an in-bench encoder model
// depends on adne_pkg, adne_if and the encoder rtl
module tb_adpcm_nibble_encoder;

  // where a random sample comes from: slow walk, close to the current level,
  // any 16-bit value, or one of the rails
  typedef enum int {
    SRC_WALK,
    SRC_TRACK,
    SRC_FULL,
    SRC_RAIL
  } sample_src_t;

  // one row of the directed table; known rows carry a byte worked out by hand
  typedef struct packed {
    logic signed [adne_pkg::SAMPLE_W-1:0] sample;
    logic                                 new_stream;
    logic                                 known;
    logic [adne_pkg::OUT_W-1:0]           byte_val;
  } sample_row_t;

  localparam int RANDOM_ITEMS  = 676;
  localparam int DRAIN_CYCLES  = 40;   // extra wait after the last expected byte
  localparam int HOLD_AT_ITEM  = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int PAUSE_AT_ITEM = 500;

  logic clk;
  logic rst_n;
  logic hold_rx = 1'b0;

  adne_in_if  in_ch ();
  adne_out_if out_ch ();

  adpcm_nibble_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  // encoder model state, mirrors the block after each accepted item
  logic signed [adne_pkg::SAMPLE_W-1:0] level_q;
  logic [adne_pkg::STEP_W-1:0]          step_q;
  logic                                 odd_q;
  logic [adne_pkg::CODE_W-1:0]          held_q;

  logic [adne_pkg::OUT_W-1:0] pending_bytes [$];
  int                         n_sent;
  int                         mismatches;
  bit                         tx_quiet;
  sample_row_t                directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // step multiplier, symmetric around a zero code
  function automatic int step_gain(input int code);
    case (code)
      -8, -7, 7: return 154;
      -6, 6:     return 128;
      -5, 5:     return 102;
      -4, 4:     return 77;
      default:   return 58;
    endcase
  endfunction

  task automatic clear_encoder_state();
    level_q = '0;
    step_q  = adne_pkg::STEP_RESET;
    odd_q   = 1'b0;
    held_q  = '0;
  endtask

  // encode one accepted sample; a byte comes out on every second code
  task automatic encode_sample(input logic signed [adne_pkg::SAMPLE_W-1:0] s, input logic ns,
                               output bit has_byte,
                               output logic [adne_pkg::OUT_W-1:0] packed_byte);
    int stp, diff, code, mag, delta;
    logic [adne_pkg::CODE_W-1:0] nib;
    // new stream restarts level, step and pairing; a held code is lost
    if (ns) begin
      level_q = '0;
      step_q  = adne_pkg::STEP_RESET;
      odd_q   = 1'b0;
    end
    stp  = int'(step_q);
    diff = int'(s) - int'(level_q);
    code = diff / stp;                 // truncates toward zero
    code = code >>> 1;                 // halves with floor
    code = clamp_int(code, -8, 7);
    nib  = code[adne_pkg::CODE_W-1:0];
    has_byte    = odd_q;
    packed_byte = {held_q, nib};
    if (odd_q) begin
      odd_q = 1'b0;
    end else begin
      held_q = nib;
      odd_q  = 1'b1;
    end
    // a zero code still pulls the level down by half a step
    mag   = (code < 0) ? -code : code;
    delta = ((1 + 2 * mag) * stp) / 2;
    if (code <= 0) begin
      delta = -delta;
    end
    level_q = clamp_int(int'(level_q) + delta, -32768, 32767);
    step_q  = clamp_int((stp * step_gain(code)) / 64, int'(adne_pkg::STEP_MIN),
                        int'(adne_pkg::STEP_MAX));
  endtask

  // offer one item, wait for the handshake, then run the model on it;
  // valid stays high between back-to-back items
  task automatic send_sample(input logic signed [adne_pkg::SAMPLE_W-1:0] s, input logic ns,
                             input logic known, input logic [adne_pkg::OUT_W-1:0] known_byte);
    int gap;
    bit has_byte;
    logic [adne_pkg::OUT_W-1:0] packed_byte;
    if ($urandom_range(0, 29) == 0) begin
      tx_quiet = !tx_quiet;
    end
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.new_stream <= ns;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_sample(s, ns, has_byte, packed_byte);
    if (has_byte) begin
      pending_bytes.push_back(known ? known_byte : packed_byte);
    end
    n_sent++;
  endtask

  // receiver: checks each byte against the oldest expectation and stalls at random
  initial begin
    int stall;
    bit rx_quiet;
    logic [adne_pkg::OUT_W-1:0] want;
    stall    = 0;
    rx_quiet = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected packed byte %02h at %0t", out_ch.packed_codes, $realtime);
          end
        end else begin
          want = pending_bytes.pop_front();
          if (out_ch.packed_codes !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("packed_codes mismatch at %0t: expected %02h, got %02h",
                       $realtime, want, out_ch.packed_codes);
            end
          end
        end
        if ($urandom_range(0, 29) == 0) begin
          rx_quiet = !rx_quiet;
        end
        stall = rx_quiet ? 0 : $urandom_range(0, 3);
      end else if (stall > 0) begin
        stall--;
      end
      out_ch.ready <= (stall == 0) && !hold_rx;
    end
  end

  // long receiver hold-off: the output register fills and the input stalls
  initial begin
    wait (n_sent >= HOLD_AT_ITEM);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // directed table: restart paths, both rails, dropped unpaired code, step decay
  initial begin
    directed_rows.push_back({16'sd0,      1'b1, 1'b0, 8'h00});
    directed_rows.push_back({16'sd0,      1'b0, 1'b1, 8'h00}); // both codes zero
    directed_rows.push_back({16'sd32767,  1'b1, 1'b0, 8'h00});
    directed_rows.push_back({-16'sd32768, 1'b0, 1'b1, 8'h78}); // max then min code
    directed_rows.push_back({-16'sd32768, 1'b1, 1'b0, 8'h00});
    directed_rows.push_back({16'sd32767,  1'b1, 1'b0, 8'h00}); // held code dropped
    directed_rows.push_back({16'sd32767,  1'b0, 1'b1, 8'h77});
    repeat (5) directed_rows.push_back({16'sd32767,  1'b0, 1'b0, 8'h00}); // top rail
    repeat (6) directed_rows.push_back({-16'sd32768, 1'b0, 1'b0, 8'h00}); // bottom rail
    directed_rows.push_back({16'sd0, 1'b1, 1'b0, 8'h00});
    repeat (5) directed_rows.push_back({16'sd0, 1'b0, 1'b0, 8'h00}); // step shrinks
  end

  // main sequence
  initial begin
    int seg_left, walk, v;
    sample_src_t src, pick;
    logic ns;
    seg_left   = 0;
    walk       = 0;
    src        = SRC_WALK;
    n_sent     = 0;
    mismatches = 0;
    tx_quiet   = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.sample     <= '0;
    in_ch.new_stream <= 1'b0;
    rst_n            <= 1'b0;
    clear_encoder_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_sample(directed_rows[k].sample, directed_rows[k].new_stream,
                  directed_rows[k].known, directed_rows[k].byte_val);
    end

    // random streams: mostly one kind of signal per stream, some mixing,
    // odd and even stream lengths so unpaired codes get dropped
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 64);
        src      = sample_src_t'($urandom_range(0, 3));
        ns       = 1'b1;
      end else begin
        ns = ($urandom_range(0, 99) == 0);
      end
      pick = ($urandom_range(0, 6) == 0) ? sample_src_t'($urandom_range(0, 3)) : src;
      case (pick)
        SRC_WALK: begin
          walk = clamp_int(walk + int'($urandom_range(0, 800)) - 400, -32768, 32767);
          v    = walk;
        end
        SRC_TRACK: v = clamp_int(int'(level_q) + int'($urandom_range(0, 40)) - 20,
                                 -32768, 32767);
        SRC_FULL:  v = int'($urandom_range(0, 65535)) - 32768;
        default:   v = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      seg_left--;

      // sender pause: let every outstanding byte drain first
      if (n_sent == PAUSE_AT_ITEM) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
      end
      send_sample(v[adne_pkg::SAMPLE_W-1:0], ns, 1'b0, 8'h00);
    end

    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/adne_pkg.sv
rtl/adne_if.sv
rtl/adne_alu.sv
rtl/adne_mul.sv
rtl/adpcm_nibble_encoder.sv
tb/tb_adpcm_nibble_encoder.sv
